FILE: hdl/ipd_pkg.sv
// Shared widths, types and limits for the inner-product distance core.
`timescale 1ns / 1ps

package ipd_pkg;

    // Lane count and field widths
    localparam int LANES      = 4;
    localparam int ELEM_BITS  = 16;
    localparam int COUNT_BITS = 3;
    localparam int ACC_BITS   = 48;
    localparam int FRAC_BITS  = 30;
    localparam int OUT_BITS   = 48;

    // Derived widths
    localparam int PROD_BITS      = 2 * ELEM_BITS;
    localparam int SUM_BITS       = PROD_BITS + $clog2(LANES) + 1;
    localparam int WIDE_BITS      = ((ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS) + 1;
    localparam int S_PAYLOAD_BITS = 2 * LANES * ELEM_BITS + COUNT_BITS;
    localparam int S_TDATA_BITS   = ((S_PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS   = ((OUT_BITS + 7) / 8) * 8;
    localparam int COUNT_LSB      = 2 * LANES * ELEM_BITS;

    // Output modes
    localparam logic MODE_DISTANCE = 1'b0;
    localparam logic MODE_DOT      = 1'b1;

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    // Saturation limits, held at the wide width
    localparam wide_t ACC_MAX_W = (wide_t'(1) <<< (ACC_BITS - 1)) - wide_t'(1);
    localparam wide_t ACC_MIN_W = -ACC_MAX_W - wide_t'(1);
    localparam wide_t OUT_MAX_W = (wide_t'(1) <<< (OUT_BITS - 1)) - wide_t'(1);
    localparam wide_t OUT_MIN_W = -OUT_MAX_W - wide_t'(1);
    localparam wide_t ONE_W     = wide_t'(1) <<< FRAC_BITS;

    // Accumulator limits at its own width
    localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

    // Control carried alongside a request through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

FILE: hdl/ipd_lane.sv
// One multiply lane: masked Q1.15 x Q1.15 product into a Q2.30 register.
`timescale 1ns / 1ps

module ipd_lane (
    input  logic          aclk,
    input  logic          adv,
    input  logic          lane_on,
    input  ipd_pkg::elem_t first_elem,
    input  ipd_pkg::elem_t second_elem,
    output ipd_pkg::prod_t prod_reg
);
    import ipd_pkg::*;

    prod_t prod_next;

    // Exact product; idle lanes contribute zero
    always_comb begin
        prod_next = first_elem * second_elem;
        if (!lane_on) begin
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: hdl/ipd_merge.sv
// Merge stage: lane sum, saturating accumulator, result and output register.
`timescale 1ns / 1ps

module ipd_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 output_mode,
    input  ipd_pkg::stage_ctl_t                  lane_ctl,
    input  ipd_pkg::prod_t                       lane_prod [ipd_pkg::LANES],
    output logic                                 adv,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ipd_pkg::M_TDATA_BITS-1:0]     m_tdata,
    output logic                                 m_tuser
);
    import ipd_pkg::*;

    // Sum stage
    sum_t       sum_reg, sum_next;
    stage_ctl_t sum_ctl_reg;

    // Accumulate stage
    acc_t                 acc_reg, acc_next;
    logic                 seen_reg, seen_next;
    acc_t                 fin_acc_reg;
    logic                 fin_sat_reg;
    logic                 fin_valid_reg;
    logic signed [ACC_BITS:0] acc_sum;
    acc_t                 acc_new;
    logic                 acc_ovf;

    // Output stage
    logic                    m_tvalid_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    wide_t                   res_w;
    logic                    res_sat;
    logic                    out_free;

    // Output register is free or being taken; the pipeline only holds when a
    // finished result has to wait behind a result still in the output register
    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = out_free || !fin_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Lane adder
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++) begin
            sum_next = sum_next + SUM_BITS'(lane_prod[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_ctl_reg <= '0;
        end else if (adv) begin
            sum_ctl_reg <= lane_ctl;
        end
    end

    // Saturating accumulate; one extra bit catches overflow
    always_comb begin
        acc_sum = (ACC_BITS + 1)'(acc_reg) + (ACC_BITS + 1)'(sum_reg);
        acc_ovf = acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1];
        if (acc_ovf) begin
            acc_new = acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_new = acc_sum[ACC_BITS-1:0];
        end
        acc_next  = acc_reg;
        seen_next = seen_reg;
        if (sum_ctl_reg.valid) begin
            if (sum_ctl_reg.last) begin
                acc_next  = '0;
                seen_next = 1'b0;
            end else begin
                acc_next  = acc_new;
                seen_next = seen_reg | acc_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (adv) begin
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            fin_valid_reg <= sum_ctl_reg.valid && sum_ctl_reg.last;
        end
    end

    // Final value of the vector pair
    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_acc_reg <= acc_new;
            fin_sat_reg <= seen_reg | acc_ovf;
        end
    end

    // Result: distance or dot; distance clamped to accumulator range, then both to output range
    always_comb begin
        res_sat = fin_sat_reg;
        if (output_mode == MODE_DOT) begin
            res_w = WIDE_BITS'(fin_acc_reg);
        end else begin
            res_w = ONE_W - WIDE_BITS'(fin_acc_reg);
            if (res_w > ACC_MAX_W) begin
                res_w   = ACC_MAX_W;
                res_sat = 1'b1;
            end else if (res_w < ACC_MIN_W) begin
                res_w   = ACC_MIN_W;
                res_sat = 1'b1;
            end
        end
        if (res_w > OUT_MAX_W) begin
            res_w   = OUT_MAX_W;
            res_sat = 1'b1;
        end else if (res_w < OUT_MIN_W) begin
            res_w   = OUT_MIN_W;
            res_sat = 1'b1;
        end
        m_tdata_next                = '0;
        m_tdata_next[OUT_BITS-1:0]  = res_w[OUT_BITS-1:0];
        m_tuser_next                = res_sat;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

FILE: hdl/inner_product_distance_core.sv
// Top level of the inner-product distance core: lanes, merge and mode register.
`timescale 1ns / 1ps

// Accepts one request of four element pairs per clock, except while the
// pipeline holds, and adds the products of the valid lanes into a saturating
// 48-bit accumulator with 30 fraction bits. On the request marked tlast it
// emits one result, either 1.0 minus the dot product or the raw dot product
// as chosen by the mode register, with m_tuser set if any saturation
// happened, and then clears the accumulator. Throughput is one request per
// cycle while the pipeline does not hold; a result passes through the lane
// multiply, lane adder, accumulator and output registers before m_tvalid
// rises. Requests keep flowing while a result waits on m_tready; the pipeline
// holds only when a second finished result reaches the occupied output
// register. Write the mode only while the core is idle.

module inner_product_distance_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Mode register write
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    // Element pairs in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // first_elem0..3, second_elem0..3, valid_lanes, zero pad
    input  logic [ipd_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic                               s_tlast,
    // Result out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_value
    output logic [ipd_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // saturated
    output logic                               m_tuser
);
    import ipd_pkg::*;

    logic                  mode_reg;
    logic                  adv;
    stage_ctl_t            lane_ctl_reg;
    prod_t                 lane_prod [LANES];
    logic [COUNT_BITS-1:0] valid_lanes;

    assign s_tready    = adv;
    assign valid_lanes = s_tdata[COUNT_LSB +: COUNT_BITS];

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_DISTANCE;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Lane-stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_ctl_reg <= '0;
        end else if (adv) begin
            lane_ctl_reg.valid <= s_tvalid;
            lane_ctl_reg.last  <= s_tlast;
        end
    end

    // Multiply lanes; a count above LANES enables them all
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ipd_lane u_lane (
            .aclk        (aclk),
            .adv         (adv),
            .lane_on     (s_tvalid && (32'(valid_lanes) > g)),
            .first_elem  (s_tdata[g * ELEM_BITS +: ELEM_BITS]),
            .second_elem (s_tdata[(LANES + g) * ELEM_BITS +: ELEM_BITS]),
            .prod_reg    (lane_prod[g])
        );
    end

    ipd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .output_mode (mode_reg),
        .lane_ctl    (lane_ctl_reg),
        .lane_prod   (lane_prod),
        .adv         (adv),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: bench/tb_inner_product_distance_core.sv
// Self-checking testbench for the inner-product distance core.
`timescale 1ns / 1ps

module tb_inner_product_distance_core;

    import ipd_pkg::*;

    localparam longint ACC_HI  = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_LO  = -ACC_HI - 1;
    localparam longint OUT_HI  = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint OUT_LO  = -OUT_HI - 1;
    localparam longint ONE_Q30 = longint'(1) <<< FRAC_BITS;
    localparam int     CYCLE_LIMIT = 1000000;

    localparam elem_t ELEM_MIN = elem_t'(-32768);
    localparam elem_t ELEM_MAX = elem_t'(32767);

    // One request as it sits in s_tdata, lane 0 of the first vector lowest
    typedef struct packed {
        logic [COUNT_BITS-1:0]  lanes;
        elem_t [LANES-1:0]      second;
        elem_t [LANES-1:0]      first;
    } pair_req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                saturated;
    } dist_result_t;

    // Running dot product per vector pair and the queue of distances still due
    class distance_scoreboard;
        longint       dot_sum;
        bit           sum_clamped;
        logic         mode;
        int           errors;
        dist_result_t pending_results[$];

        function new();
            dot_sum     = 0;
            sum_clamped = 0;
            mode        = MODE_DISTANCE;
            errors      = 0;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Fold one accepted request into the sum; a last request yields a result
        function void take_request(pair_req_t r, logic last);
            longint item_sum;
            longint next_sum;
            longint value;
            logic   flag;
            int     n;
            n = (r.lanes > LANES) ? LANES : int'(r.lanes);
            item_sum = 0;
            for (int i = 0; i < n; i++)
                item_sum += longint'($signed(r.first[i])) * longint'($signed(r.second[i]));
            next_sum = dot_sum + item_sum;
            if (next_sum > ACC_HI) begin
                dot_sum     = ACC_HI;
                sum_clamped = 1'b1;
            end else if (next_sum < ACC_LO) begin
                dot_sum     = ACC_LO;
                sum_clamped = 1'b1;
            end else begin
                dot_sum = next_sum;
            end
            if (!last)
                return;
            flag  = sum_clamped;
            value = (mode == MODE_DOT) ? dot_sum : ONE_Q30 - dot_sum;
            // distance clamps at the accumulator range, then at the output range
            if (value > ACC_HI) begin
                value = ACC_HI;
                flag  = 1'b1;
            end else if (value < ACC_LO) begin
                value = ACC_LO;
                flag  = 1'b1;
            end
            if (value > OUT_HI) begin
                value = OUT_HI;
                flag  = 1'b1;
            end else if (value < OUT_LO) begin
                value = OUT_LO;
                flag  = 1'b1;
            end
            pending_results.push_back('{value: value[OUT_BITS-1:0], saturated: flag});
            dot_sum     = 0;
            sum_clamped = 1'b0;
        endfunction

        task check_result(logic [OUT_BITS-1:0] value, logic saturated);
            dist_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing pending", $signed(value)));
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("result value %0d, expected %0d",
                                          $signed(value), $signed(want.value)));
            if (saturated !== want.saturated)
                report_mismatch($sformatf("saturated flag %b, expected %b",
                                          saturated, want.saturated));
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic                      cfg_wr_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      m_tuser;

    distance_scoreboard sb;
    int send_idle_pct = 27;
    int recv_idle_pct = 50;
    int cycle_count   = 0;

    inner_product_distance_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[inner_product_distance_core] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Input monitor feeds the predictor
    always @(posedge aclk) begin : watch_requests
        pair_req_t seen;
        if (aresetn && s_tvalid && s_tready) begin
            seen = s_tdata[S_PAYLOAD_BITS-1:0];
            sb.take_request(seen, s_tlast);
        end
    end

    // Output monitor
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[OUT_BITS-1:0], m_tuser);

    function automatic elem_t pick_elem();
        case ($urandom_range(7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return elem_t'(0);
            3:       return elem_t'(-1);
            4:       return elem_t'(1);
            default: return elem_t'($urandom_range(65535));
        endcase
    endfunction

    function automatic pair_req_t random_request();
        pair_req_t r;
        for (int i = 0; i < LANES; i++) begin
            r.first[i]  = pick_elem();
            r.second[i] = pick_elem();
        end
        // mostly legal lane counts, sometimes zero or past the lane count
        if ($urandom_range(9) < 8)
            r.lanes = COUNT_BITS'($urandom_range(4, 1));
        else
            r.lanes = COUNT_BITS'($urandom_range(7));
        return r;
    endfunction

    function automatic pair_req_t uniform_request(elem_t a, elem_t b,
                                                  logic [COUNT_BITS-1:0] lanes);
        pair_req_t r;
        for (int i = 0; i < LANES; i++) begin
            r.first[i]  = a;
            r.second[i] = b;
        end
        r.lanes = lanes;
        return r;
    endfunction

    // Present one request, with random idle cycles ahead of it
    task automatic send_request(pair_req_t r, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS - S_PAYLOAD_BITS){1'b0}}, r};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Drain the core, then write the mode register
    task automatic write_mode(logic value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.mode = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Extremes, empty and oversized lane counts, and a short multi-request vector
    task automatic run_directed();
        pair_req_t r;
        send_request(uniform_request(ELEM_MIN, ELEM_MIN, COUNT_BITS'(4)), 1'b1);
        send_request(uniform_request(ELEM_MAX, ELEM_MAX, COUNT_BITS'(4)), 1'b1);
        send_request(uniform_request(ELEM_MIN, ELEM_MAX, COUNT_BITS'(4)), 1'b1);
        r = random_request();
        r.lanes = '0;
        send_request(r, 1'b1);
        send_request(uniform_request(ELEM_MAX, ELEM_MIN, COUNT_BITS'(7)), 1'b1);
        r = random_request();
        r.lanes = COUNT_BITS'(5);
        send_request(r, 1'b1);
        r = random_request();
        r.lanes = COUNT_BITS'(6);
        send_request(r, 1'b1);
        send_request(uniform_request(elem_t'(-1), elem_t'(1), COUNT_BITS'(1)), 1'b1);
        send_request(uniform_request(elem_t'(0), ELEM_MIN, COUNT_BITS'(3)), 1'b1);
        r = random_request();
        r.lanes = COUNT_BITS'(2);
        send_request(r, 1'b0);
        r = random_request();
        r.lanes = COUNT_BITS'(4);
        send_request(r, 1'b0);
        r = random_request();
        r.lanes = COUNT_BITS'(3);
        send_request(r, 1'b1);
    endtask

    // Random vector pairs of mostly short length, with occasional mode changes
    task automatic run_random(int n_requests);
        int sent;
        int len;
        sent = 0;
        while (sent < n_requests) begin
            if ($urandom_range(11) == 0)
                write_mode(logic'($urandom_range(1)));
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(5, 1);
            for (int j = 0; j < len; j++)
                send_request(random_request(), j == len - 1);
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        run_directed();
        write_mode(MODE_DOT);
        run_directed();
        run_random(180);

        // roles swapped
        send_idle_pct = 50;
        recv_idle_pct = 27;
        run_random(180);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(190);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (sb.errors == 0)
            $display("[inner_product_distance_core] OK");
        else
            $display("[inner_product_distance_core] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/ipd_pkg.sv
hdl/ipd_lane.sv
hdl/ipd_merge.sv
hdl/inner_product_distance_core.sv
bench/tb_inner_product_distance_core.sv
